[sv/dnsrp_pkg.sv]
// Shared types and constants of the DNS reply parser.
// No dependencies; every other file imports this package.
package dnsrp_pkg;

  // Input beat: one payload byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Result beat, one per packet.
  typedef struct packed {
    logic        accepted;
    logic [3:0]  response_code;
    logic        answer_found;
    logic [31:0] address;
    logic [31:0] time_to_live;
  } out_beat_t;

  // Result handed from the parser to the output register.
  typedef struct packed {
    logic      fire;
    out_beat_t beat;
  } result_t;

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        REG_EXPECTED_ID = 1'b0;   // register index, paddr[2]

  // Parse phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_QNAME  = 3'd1;
  localparam logic [2:0] PH_QFIXED = 3'd2;
  localparam logic [2:0] PH_ANAME  = 3'd3;
  localparam logic [2:0] PH_AFIXED = 3'd4;
  localparam logic [2:0] PH_ADATA  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // Protocol constants.
  localparam logic [3:0]  HEADER_LEN    = 4'd12;
  localparam logic [3:0]  QFIXED_LEN    = 4'd4;
  localparam logic [3:0]  AFIXED_LEN    = 4'd10;
  localparam logic [3:0]  AFIELDS_LEN   = 4'd8;
  localparam logic [7:0]  QR_MASK       = 8'h80;
  localparam logic [7:0]  RCODE_MASK    = 8'h0F;
  localparam logic [7:0]  PTR_MASK      = 8'hC0;
  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] CLASS_IN      = 16'd1;
  localparam logic [15:0] A_DATA_LEN    = 16'd4;

endpackage

[sv/dnsrp_cfg.sv]
// APB-style register file of the DNS reply parser: holds expected_id.
// Depends on dnsrp_pkg.
module dnsrp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dnsrp_pkg::CfgAddrW-1:0] paddr,
  input  logic [dnsrp_pkg::CfgDataW-1:0] pwdata,
  output logic [dnsrp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic [15:0]                   expected_id
);
  import dnsrp_pkg::*;

  logic [15:0] expected_id_r;
  logic [15:0] expected_id_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    expected_id_nxt = expected_id_r;
    if (wr_en && paddr[2] == REG_EXPECTED_ID) begin
      expected_id_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= '0;
    end else begin
      expected_id_r <= expected_id_nxt;
    end
  end

  assign prdata      = (paddr[2] == REG_EXPECTED_ID) ?
                       {{(CfgDataW-16){1'b0}}, expected_id_r} : '0;
  assign expected_id = expected_id_r;

endmodule

[sv/dnsrp_parse.sv]
// Byte-wise parse state of the DNS reply parser and the per-packet result.
// Depends on dnsrp_pkg.
module dnsrp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat_en,
  input  dnsrp_pkg::in_beat_t beat,
  input  logic [15:0]         expected_id,
  output dnsrp_pkg::result_t  result
);
  import dnsrp_pkg::*;

  typedef struct packed {
    logic [3:0]  byte_count;
    logic [2:0]  parse_phase;
    logic        header_ok;
    logic [3:0]  rcode_held;
    logic [15:0] question_left;
    logic [15:0] answer_left;
    logic [7:0]  label_left;
    logic [3:0]  field_index;
    logic [63:0] record_fields;
    logic [15:0] data_left;
    logic [31:0] address_shift;
    logic [31:0] found_addr;
    logic [31:0] found_ttl;
    logic        found_flag;
  } pkt_t;

  pkt_t        st_r;
  pkt_t        st_upd;
  pkt_t        st_nxt;
  logic [7:0]  b;
  logic        name_done;
  logic [3:0]  name_fi;
  logic [7:0]  name_ll;
  logic [3:0]  bc_inc;
  logic        acc;
  logic        hit;

  assign b = beat.data_byte;

  // One name byte: label skip, end marker or two-byte compression pointer.
  always_comb begin
    name_done = 1'b0;
    name_fi   = st_r.field_index;
    name_ll   = st_r.label_left;
    if (st_r.field_index != '0) begin
      name_fi   = '0;
      name_done = 1'b1;
    end else if (st_r.label_left != '0) begin
      name_ll = st_r.label_left - 8'd1;
    end else if (b == '0) begin
      name_done = 1'b1;
    end else if ((b & PTR_MASK) == PTR_MASK) begin
      name_fi = 4'd1;
    end else begin
      name_ll = b;
    end
  end

  assign bc_inc = st_r.byte_count + 4'd1;

  always_comb begin
    st_upd = st_r;
    case (st_r.parse_phase)
      PH_HEADER: begin
        case (st_r.byte_count)
          4'd0: st_upd.header_ok = (b == expected_id[15:8]);
          4'd1: st_upd.header_ok = st_r.header_ok && (b == expected_id[7:0]);
          4'd2: st_upd.header_ok = st_r.header_ok && ((b & QR_MASK) != '0);
          4'd3: st_upd.rcode_held = b[3:0] & RCODE_MASK[3:0];
          4'd4: st_upd.question_left = {b, 8'h00};
          4'd5: st_upd.question_left = {st_r.question_left[15:8], b};
          4'd6: st_upd.answer_left = {b, 8'h00};
          4'd7: st_upd.answer_left = {st_r.answer_left[15:8], b};
          default: ;
        endcase
        st_upd.byte_count = bc_inc;
        if (bc_inc >= HEADER_LEN) begin
          st_upd.byte_count = HEADER_LEN;
          if (!st_upd.header_ok) begin
            st_upd.parse_phase = PH_DONE;
          end else if (st_upd.question_left != '0) begin
            st_upd.parse_phase = PH_QNAME;
          end else begin
            st_upd.field_index = '0;
            st_upd.parse_phase = (st_upd.answer_left != '0) ? PH_ANAME : PH_DONE;
          end
        end
      end
      PH_QNAME: begin
        st_upd.field_index = name_fi;
        st_upd.label_left  = name_ll;
        if (name_done) begin
          st_upd.field_index = '0;
          st_upd.parse_phase = PH_QFIXED;
        end
      end
      PH_QFIXED: begin
        st_upd.field_index = st_r.field_index + 4'd1;
        if (st_upd.field_index >= QFIXED_LEN) begin
          st_upd.field_index   = '0;
          st_upd.question_left = st_r.question_left - 16'd1;
          if (st_upd.question_left != '0) begin
            st_upd.parse_phase = PH_QNAME;
          end else begin
            st_upd.parse_phase = (st_r.answer_left != '0) ? PH_ANAME : PH_DONE;
          end
        end
      end
      PH_ANAME: begin
        st_upd.field_index = name_fi;
        st_upd.label_left  = name_ll;
        if (name_done) begin
          st_upd.field_index   = '0;
          st_upd.record_fields = '0;
          st_upd.data_left     = '0;
          st_upd.parse_phase   = PH_AFIXED;
        end
      end
      PH_AFIXED: begin
        if (st_r.field_index < AFIELDS_LEN) begin
          st_upd.record_fields = {st_r.record_fields[55:0], b};
        end else begin
          st_upd.data_left = {st_r.data_left[7:0], b};
        end
        st_upd.field_index = st_r.field_index + 4'd1;
        if (st_upd.field_index >= AFIXED_LEN) begin
          st_upd.field_index   = '0;
          st_upd.address_shift = '0;
          if (st_upd.record_fields[63:48] == TYPE_A &&
              st_upd.record_fields[47:32] == CLASS_IN &&
              st_upd.data_left == A_DATA_LEN) begin
            st_upd.field_index = 4'd1;
            st_upd.parse_phase = PH_ADATA;
          end else if (st_upd.data_left == '0) begin
            st_upd.answer_left = st_r.answer_left - 16'd1;
            st_upd.parse_phase = (st_upd.answer_left != '0) ? PH_ANAME : PH_DONE;
          end else begin
            st_upd.parse_phase = PH_ADATA;
          end
        end
      end
      PH_ADATA: begin
        st_upd.data_left = st_r.data_left - 16'd1;
        if (st_r.field_index != '0) begin
          st_upd.address_shift = {st_r.address_shift[23:0], b};
        end
        if (st_upd.data_left == '0) begin
          if (st_r.field_index != '0) begin
            st_upd.found_addr  = st_upd.address_shift;
            st_upd.found_ttl   = st_r.record_fields[31:0];
            st_upd.found_flag  = 1'b1;
            st_upd.field_index = '0;
            st_upd.parse_phase = PH_DONE;
          end else begin
            st_upd.field_index = '0;
            st_upd.answer_left = st_r.answer_left - 16'd1;
            st_upd.parse_phase = (st_upd.answer_left != '0) ? PH_ANAME : PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  // The last byte closes the packet; state returns to reset values.
  always_comb begin
    st_nxt = st_r;
    if (beat_en) begin
      st_nxt = beat.last_byte ? pkt_t'('0) : st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign acc = (st_upd.byte_count >= HEADER_LEN) && st_upd.header_ok;
  assign hit = acc && st_upd.found_flag;

  assign result.fire               = beat_en & beat.last_byte;
  assign result.beat.accepted      = acc;
  assign result.beat.response_code = acc ? st_upd.rcode_held : 4'd0;
  assign result.beat.answer_found  = hit;
  assign result.beat.address       = hit ? st_upd.found_addr : 32'd0;
  assign result.beat.time_to_live  = hit ? st_upd.found_ttl : 32'd0;

endmodule

[sv/dnsrp_outreg.sv]
// Result register of the DNS reply parser, with valid/stall towards the sink.
// Depends on dnsrp_pkg.
module dnsrp_outreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dnsrp_pkg::result_t   result,
  input  logic                 out_stall,
  output logic                 out_valid,
  output dnsrp_pkg::out_beat_t out_data,
  output logic                 hold
);
  import dnsrp_pkg::*;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_beat_t out_data_r;

  // Register busy and the sink not taking it.
  assign hold = out_valid_r & out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (result.fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.fire) begin
      out_data_r <= result.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/dns_reply_parser.sv]
// DNS reply parser, top level. Instantiates dnsrp_cfg, dnsrp_parse and
// dnsrp_outreg; depends on dnsrp_pkg.
//
// Takes the UDP payload of a DNS reply one byte per input beat, with
// last_byte set on the final byte, and returns exactly one result beat per
// packet, issued in the cycle after the last byte is taken. The header (12
// bytes) is checked against expected_id and the response bit, the rcode is
// kept, question entries (plain or compressed names plus 4 fixed bytes) are
// skipped and answer records are walked until the first IN A record with 4
// complete data bytes, whose address and TTL are reported. Short packets,
// header mismatches and truncated records give zeroed fields as described
// for each output. Every byte is absorbed by the parse state
// registers, so one byte per clock is sustained; the only thing that holds
// the input back is a result beat waiting in the output register while the
// sink stalls. expected_id is written over the APB-style port at byte
// address 0 and must only change between packets.
module dns_reply_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dnsrp_pkg::in_beat_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dnsrp_pkg::out_beat_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dnsrp_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dnsrp_pkg::CfgDataW-1:0]    pwdata,
  output logic [dnsrp_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready
);
  import dnsrp_pkg::*;

  logic [15:0] expected_id;
  logic        in_take;    // input beat accepted this cycle
  logic        hold;
  result_t     result;

  assign in_stall = hold;
  assign in_take  = in_valid & ~hold;

  dnsrp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .expected_id (expected_id)
  );

  // Parse state steps once per accepted byte; result formed on the last one.
  dnsrp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_en     (in_take),
    .beat        (in_data),
    .expected_id (expected_id),
    .result      (result)
  );

  dnsrp_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .hold      (hold)
  );

endmodule

[test/dns_reply_parser_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for dns_reply_parser: packet bytes in, one reply beat out.
// Depends on dnsrp_pkg and the parser RTL; predicts each reply with its own parse model.
module dns_reply_parser_test;
  import dnsrp_pkg::*;

  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 4;       // result lands in the cycle after the last byte
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT_NS  = 5000000;
  localparam logic [15:0] DIRECTED_ID = 16'hA5C3;
  localparam logic [CfgAddrW-1:0] ID_ADDR = CfgAddrW'({REG_EXPECTED_ID, 2'b00});

  // record types and classes beyond the IN A pair
  localparam logic [15:0] TYPE_NS    = 16'd2;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  localparam logic [15:0] CLASS_CH   = 16'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  dns_reply_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;

  out_beat_t pending_replies[$];
  logic [7:0] pkt[$];

  // ---------------------------------------------------------------------------
  // Parse model: own copy of the expected ID and of the per-packet state
  // ---------------------------------------------------------------------------
  logic [15:0] model_id;
  logic [3:0]  hdr_count;
  logic [2:0]  phase;
  logic        hdr_ok;
  logic [3:0]  rcode;
  logic [15:0] q_left;
  logic [15:0] a_left;
  logic [7:0]  lbl_left;
  logic [3:0]  fidx;          // fixed-byte count; also pointer-pending / A-match flag
  logic [63:0] rec_fields;    // type, class, TTL
  logic [15:0] d_left;
  logic [31:0] addr_acc;
  logic [31:0] got_addr;
  logic [31:0] got_ttl;
  logic        got_flag;

  function automatic void clear_parse();
    hdr_count  = '0;
    phase      = PH_HEADER;
    hdr_ok     = 1'b0;
    rcode      = '0;
    q_left     = '0;
    a_left     = '0;
    lbl_left   = '0;
    fidx       = '0;
    rec_fields = '0;
    d_left     = '0;
    addr_acc   = '0;
    got_addr   = '0;
    got_ttl    = '0;
    got_flag   = 1'b0;
  endfunction

  function automatic void open_answers();
    fidx  = '0;
    phase = (a_left != 16'd0) ? PH_ANAME : PH_DONE;
  endfunction

  function automatic void close_record();
    a_left = a_left - 16'd1;
    open_answers();
  endfunction

  // high once the name is complete
  function automatic logic name_byte(logic [7:0] b);
    if (fidx != 4'd0) begin
      fidx = '0;
      return 1'b1;
    end
    if (lbl_left != 8'd0) begin
      lbl_left = lbl_left - 8'd1;
      return 1'b0;
    end
    if (b == 8'h00) return 1'b1;
    if ((b & PTR_MASK) == PTR_MASK) begin
      fidx = 4'd1;
      return 1'b0;
    end
    lbl_left = b;               // 01/10 top bits count as plain lengths too
    return 1'b0;
  endfunction

  function automatic void header_step(logic [7:0] b);
    case (hdr_count)
      4'd0: hdr_ok = (b == model_id[15:8]);
      4'd1: hdr_ok = hdr_ok && (b == model_id[7:0]);
      4'd2: hdr_ok = hdr_ok && ((b & QR_MASK) != 8'd0);
      4'd3: rcode = 4'(b & RCODE_MASK);
      4'd4: q_left = {b, 8'h00};
      4'd5: q_left = q_left | 16'(b);
      4'd6: a_left = {b, 8'h00};
      4'd7: a_left = a_left | 16'(b);
      default: ;
    endcase
    hdr_count = hdr_count + 4'd1;
    if (hdr_count >= HEADER_LEN) begin
      hdr_count = HEADER_LEN;
      if (!hdr_ok) phase = PH_DONE;
      else if (q_left != 16'd0) phase = PH_QNAME;
      else open_answers();
    end
  endfunction

  function automatic void parse_step(logic [7:0] b);
    case (phase)
      PH_HEADER: header_step(b);
      PH_QNAME: begin
        if (name_byte(b)) begin
          fidx  = '0;
          phase = PH_QFIXED;
        end
      end
      PH_QFIXED: begin
        fidx = fidx + 4'd1;
        if (fidx >= QFIXED_LEN) begin
          fidx   = '0;
          q_left = q_left - 16'd1;
          if (q_left != 16'd0) phase = PH_QNAME;
          else open_answers();
        end
      end
      PH_ANAME: begin
        if (name_byte(b)) begin
          fidx       = '0;
          rec_fields = '0;
          d_left     = '0;
          phase      = PH_AFIXED;
        end
      end
      PH_AFIXED: begin
        if (fidx < AFIELDS_LEN) rec_fields = {rec_fields[55:0], b};
        else d_left = {d_left[7:0], b};
        fidx = fidx + 4'd1;
        if (fidx >= AFIXED_LEN) begin
          fidx     = '0;
          addr_acc = '0;
          if (rec_fields[63:48] == TYPE_A && rec_fields[47:32] == CLASS_IN &&
              d_left == A_DATA_LEN) begin
            fidx  = 4'd1;
            phase = PH_ADATA;
          end else if (d_left == 16'd0) begin
            close_record();
          end else begin
            phase = PH_ADATA;
          end
        end
      end
      PH_ADATA: begin
        d_left = d_left - 16'd1;
        if (fidx != 4'd0) addr_acc = {addr_acc[23:0], b};
        if (d_left == 16'd0) begin
          if (fidx != 4'd0) begin
            got_addr = addr_acc;
            got_ttl  = rec_fields[31:0];
            got_flag = 1'b1;
            fidx     = '0;
            phase    = PH_DONE;
          end else begin
            close_record();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic out_beat_t reply_now();
    out_beat_t r;
    logic acc;
    acc = (hdr_count >= HEADER_LEN) && hdr_ok;
    r.accepted      = acc;
    r.response_code = acc ? rcode : 4'd0;
    r.answer_found  = acc && got_flag;
    r.address       = (acc && got_flag) ? got_addr : 32'd0;
    r.time_to_live  = (acc && got_flag) ? got_ttl : 32'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Packet building
  // ---------------------------------------------------------------------------
  function automatic void put16(logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] id, logic [7:0] flags, logic [7:0] codes,
                                     logic [15:0] qd, logic [15:0] an);
    put16(id);
    pkt.push_back(flags);
    pkt.push_back(codes);
    put16(qd);
    put16(an);
    put_random(4);
  endfunction

  // plain labels, then a root byte or a compression pointer
  function automatic void put_name(int labels, bit ptr);
    int len;
    repeat (labels) begin
      len = $urandom_range(4, 1);
      pkt.push_back(8'(len));
      put_random(len);
    end
    if (ptr) begin
      pkt.push_back(PTR_MASK | 8'($urandom_range(63)));
      put_random(1);
    end else begin
      pkt.push_back(8'h00);
    end
  endfunction

  function automatic void put_odd_name(logic [7:0] len);
    pkt.push_back(len);
    put_random(len);
    pkt.push_back(8'h00);
  endfunction

  // fixed part of an answer record; the caller adds name and data
  function automatic void put_record(logic [15:0] rtype, logic [15:0] rclass,
                                     logic [31:0] ttl, logic [15:0] rdlen);
    put16(rtype);
    put16(rclass);
    put16(ttl[31:16]);
    put16(ttl[15:0]);
    put16(rdlen);
  endfunction

  function automatic void put_random_name();
    if ($urandom_range(39) == 0) put_odd_name(8'($urandom_range(191, 64)));
    else put_name($urandom_range(2), 1'($urandom_range(1)));
  endfunction

  function automatic void put_body(int qd, int an);
    logic [15:0] rdlen;
    repeat (qd) begin
      put_random_name();
      put_random(4);
    end
    repeat (an) begin
      put_random_name();
      case ($urandom_range(5))
        0, 1: rdlen = A_DATA_LEN;
        2: rdlen = A_DATA_LEN;
        3: rdlen = 16'd16;
        4: rdlen = 16'($urandom_range(6));
        default: rdlen = 16'($urandom_range(5));
      endcase
      case (rdlen)
        A_DATA_LEN: begin
          if ($urandom_range(2) == 0) put_record(TYPE_A, 16'($urandom), $urandom, rdlen);
          else put_record(TYPE_A, CLASS_IN, $urandom, rdlen);
        end
        16'd16: put_record(TYPE_AAAA, CLASS_IN, $urandom, rdlen);
        default: begin
          if ($urandom_range(1)) put_record(TYPE_A, CLASS_IN, $urandom, rdlen);
          else put_record(16'($urandom), 16'($urandom), $urandom, rdlen);
        end
      endcase
      put_random(rdlen);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    in_beat_t beat;
    beat.data_byte = b;
    beat.last_byte = last;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_step(beat.data_byte);
    if (beat.last_byte) begin
      pending_replies.push_back(reply_now());
      clear_parse();
    end
  endtask

  task automatic send_reply();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  // drop valid and hold off until every reply is out
  task automatic wait_drained();
    int n = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write expected_id, then read it back
  task automatic cfg_write(logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ID_ADDR;
    pwdata  <= CfgDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_id = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CfgDataW'(value)) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: expected_id read back %08h, expected %08h", $time, prdata,
                 CfgDataW'(value));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------------------
  // Reply checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_replies
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: reply beat with none outstanding: acc %0b rcode %0h found %0b",
                   $time, out_data.accepted, out_data.response_code, out_data.answer_found);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.accepted !== want.accepted ||
            out_data.response_code !== want.response_code ||
            out_data.answer_found !== want.answer_found ||
            out_data.address !== want.address ||
            out_data.time_to_live !== want.time_to_live) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: bad reply: expected acc %0b rcode %0h found %0b addr %08h",
                      " ttl %08h, got acc %0b rcode %0h found %0b addr %08h ttl %08h"},
                     $time, want.accepted, want.response_code, want.answer_found,
                     want.address, want.time_to_live, out_data.accepted,
                     out_data.response_code, out_data.answer_found, out_data.address,
                     out_data.time_to_live);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // runs with the reset value of expected_id (zero)
  task automatic test_short_packets();
    pkt.push_back(8'hFF);
    send_reply();
    // one byte short of a header
    put_header(16'h0000, QR_MASK, 8'h00, 16'h0000, 16'h0000);
    void'(pkt.pop_back());
    send_reply();
    // bare header, highest rcode
    put_header(16'h0000, 8'hFF, 8'hFF, 16'h0000, 16'h0000);
    send_reply();
  endtask

  task automatic test_header_checks();
    wait_drained();
    cfg_write(16'hFFFF);
    put_header(16'hFFFF, 8'hFF, 8'h00, 16'h0000, 16'h0001);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, 32'hFFFF_FFFF, A_DATA_LEN);
    repeat (4) pkt.push_back(8'hFF);
    send_reply();
    // wrong high ID byte, then wrong low ID byte
    put_header(16'h7FFF, 8'hFF, 8'h00, 16'h0000, 16'h0001);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    put_header(16'hFFFE, 8'hFF, 8'h00, 16'h0000, 16'h0001);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    // response bit clear
    put_header(16'hFFFF, 8'h7F, 8'hF3, 16'h0000, 16'h0001);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    wait_drained();
    cfg_write(DIRECTED_ID);
  endtask

  task automatic test_question_names();
    put_header(DIRECTED_ID, QR_MASK, 8'h05, 16'd1, 16'd1);
    put_name(2, 0);
    put_random(4);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    // pointer name and root name
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd2, 16'd1);
    put_name(0, 1);
    put_random(4);
    put_name(0, 0);
    put_random(4);
    put_name(1, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    // label length bytes with top bits 01 and 10 are plain lengths
    put_header(DIRECTED_ID, QR_MASK, 8'h02, 16'd1, 16'd1);
    put_odd_name(8'h40);
    put_random(4);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
    put_header(DIRECTED_ID, QR_MASK, 8'h01, 16'd1, 16'd0);
    put_odd_name(8'hBF);
    put_random(4);
    send_reply();
    // all-ones pointer
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd1, 16'd1);
    pkt.push_back(8'hFF);
    pkt.push_back(8'hFF);
    put_random(4);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    send_reply();
  endtask

  task automatic test_answer_records();
    // non-matching records ahead of the A record; zero address and TTL
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd0, 16'd3);
    put_name(1, 0);
    put_record(TYPE_CNAME, CLASS_IN, $urandom, 16'd3);
    put_random(3);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_CH, $urandom, A_DATA_LEN);
    put_random(4);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, 32'd0, A_DATA_LEN);
    repeat (4) pkt.push_back(8'h00);
    send_reply();
    // wrong data length and an empty record: nothing found
    put_header(DIRECTED_ID, QR_MASK, 8'h0A, 16'd0, 16'd3);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, $urandom, 16'd5);
    put_random(5);
    put_name(0, 1);
    put_record(TYPE_NS, CLASS_IN, $urandom, 16'd0);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, 16'd3);
    put_random(3);
    send_reply();
    // second A record and trailing bytes are ignored
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd0, 16'd2);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(4);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(7);
    send_reply();
    // no answers, junk after the question
    put_header(DIRECTED_ID, QR_MASK, 8'h03, 16'd1, 16'd0);
    put_name(1, 0);
    put_random(9);
    send_reply();
  endtask

  task automatic test_early_end();
    // address bytes cut short
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd0, 16'd1);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, $urandom, A_DATA_LEN);
    put_random(3);
    send_reply();
    // inside the fixed record fields
    put_header(DIRECTED_ID, QR_MASK, 8'h04, 16'd0, 16'd1);
    put_name(0, 1);
    put16(TYPE_A);
    pkt.push_back(8'h00);
    send_reply();
    // on the first byte of a compression pointer
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd1, 16'd1);
    pkt.push_back(PTR_MASK);
    send_reply();
    // answer count beyond the records present
    put_header(DIRECTED_ID, QR_MASK, 8'h00, 16'd0, 16'd5);
    put_name(0, 0);
    put_record(TYPE_CNAME, CLASS_IN, $urandom, 16'd2);
    put_random(2);
    send_reply();
  endtask

  // mostly well-formed replies, some cut short, some broken or pure noise
  task automatic random_reply();
    int sel;
    int qd;
    int an;
    sel = $urandom_range(99);
    qd  = $urandom_range(2);
    an  = $urandom_range(3);
    if (sel < 85) begin
      put_header(model_id, QR_MASK | 8'($urandom_range(127)), 8'($urandom), 16'(qd), 16'(an));
      put_body(qd, an);
      put_random($urandom_range(2));
      if (sel >= 70) repeat ($urandom_range(pkt.size() - 1)) void'(pkt.pop_back());
    end else if (sel < 90) begin
      if ($urandom_range(1))
        put_header(model_id ^ (16'd1 << $urandom_range(15)),
                   QR_MASK | 8'($urandom_range(127)), 8'($urandom), 16'(qd), 16'(an));
      else
        put_header(model_id, 8'($urandom_range(127)), 8'($urandom), 16'(qd), 16'(an));
      put_body(qd, an);
    end else if (sel < 95) begin
      put_random($urandom_range(20, 1));
    end else begin
      put_header(model_id, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      put_random($urandom_range(30));
    end
    send_reply();
  endtask

  task automatic test_random_replies(int send_pct, int recv_pct, logic [15:0] id, int target);
    int start;
    bit paused;
    paused = 1'b0;
    wait_drained();
    cfg_write(id);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    start         = bytes_sent;
    while (bytes_sent - start < target) begin
      random_reply();
      // once per phase the sender waits for the replies to empty out
      if (!paused && bytes_sent - start >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    model_id = '0;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    stall_pct     = 84;
    test_short_packets();
    test_header_checks();
    test_question_names();
    test_answer_records();
    test_early_end();
    test_random_replies(30, 84, 16'($urandom), 270);
    test_random_replies(84, 30, 16'h0000, 270);
    test_random_replies(0, 0, 16'hFFFF, 270);
    wait_drained();
    if (pending_replies.size() != 0) begin
      mismatch_count += pending_replies.size();
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
